// File: rtl/obb_obb_separating_axis_test_unit_defines.svh
// assertion macros shared by the oriented box overlap rtl
// no dependencies; clk and rst_n must exist in the including module
`ifndef OBB_OBB_SEPARATING_AXIS_TEST_UNIT_DEFINES_SVH
`define OBB_OBB_SEPARATING_AXIS_TEST_UNIT_DEFINES_SVH

// same-cycle implication, checked outside reset
`define OBBSAT_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked outside reset
`define OBBSAT_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/obbsat_pkg.sv
`timescale 1ns / 1ps
// widths and shared types for the oriented box separating axis test
// no dependencies

package obbsat_pkg;

    localparam int CTR_W      = 32;  // center coordinate, signed q16.16
    localparam int HALF_W     = 31;  // half size, unsigned q15.16
    localparam int AX_W       = 16;  // axis component, signed q1.14
    localparam int DIF_W      = CTR_W + 1;     // center difference
    localparam int LAX_W      = AX_W + 1;      // candidate axis, may be negated
    localparam int PROD_W     = DIF_W + LAX_W; // difference times axis
    localparam int DSUM_W     = PROD_W + 1;    // dot product of difference
    localparam int DMAG_W     = 49;            // magnitude fits 2^48
    localparam int FRAC_SH    = 14;            // q.30 to q.44 alignment
    localparam int DPROJ_W    = DMAG_W + FRAC_SH;
    localparam int TERM_W     = LAX_W + AX_W;  // axis times axis product
    localparam int TSUM_W     = TERM_W + 1;    // axis dot product
    localparam int EMAG_W     = 32;            // magnitude fits 2^31
    localparam int EXT_W      = HALF_W + EMAG_W;
    localparam int RPAIR_W    = EXT_W + 1;
    localparam int RSUM_W     = RPAIR_W + 1;
    localparam int NUM_AXES   = 4;
    localparam int NUM_STAGES = 7;

    // load enables for the lane stages
    typedef struct packed {
        logic s2;
        logic s3;
        logic s4;
        logic s5;
        logic s6;
    } lane_en_t;

endpackage

// File: rtl/obbsat_axis_lane.sv
`timescale 1ns / 1ps
// one candidate axis: projects center gap and both boxes, flags separation
// depends on obbsat_pkg; stage enables come from the top level

module obbsat_axis_lane (
    input  logic                                 clk,
    input  obbsat_pkg::lane_en_t                 en,
    input  logic signed [obbsat_pkg::DIF_W-1:0]  dx,
    input  logic signed [obbsat_pkg::DIF_W-1:0]  dy,
    input  logic signed [obbsat_pkg::LAX_W-1:0]  lx,
    input  logic signed [obbsat_pkg::LAX_W-1:0]  ly,
    input  logic        [obbsat_pkg::HALF_W-1:0] a_half_width,
    input  logic        [obbsat_pkg::HALF_W-1:0] a_half_height,
    input  logic signed [obbsat_pkg::AX_W-1:0]   a_axis_cos,
    input  logic signed [obbsat_pkg::AX_W-1:0]   a_axis_sin,
    input  logic        [obbsat_pkg::HALF_W-1:0] b_half_width,
    input  logic        [obbsat_pkg::HALF_W-1:0] b_half_height,
    input  logic signed [obbsat_pkg::AX_W-1:0]   b_axis_cos,
    input  logic signed [obbsat_pkg::AX_W-1:0]   b_axis_sin,
    output logic                                 sep
);

    // stage 2: products
    logic signed [obbsat_pkg::PROD_W-1:0] pdx_reg, pdy_reg;
    logic signed [obbsat_pkg::TERM_W-1:0] au1_reg, au2_reg, av1_reg, av2_reg;
    logic signed [obbsat_pkg::TERM_W-1:0] bu1_reg, bu2_reg, bv1_reg, bv2_reg;
    logic        [obbsat_pkg::HALF_W-1:0] ahw2_reg, ahh2_reg, bhw2_reg, bhh2_reg;

    // stage 3: magnitudes
    logic signed [obbsat_pkg::DSUM_W-1:0] dsum_next, dabs_next;
    logic signed [obbsat_pkg::TSUM_W-1:0] adu_next, adv_next, bdu_next, bdv_next;
    logic signed [obbsat_pkg::TSUM_W-1:0] aduabs_next, advabs_next;
    logic signed [obbsat_pkg::TSUM_W-1:0] bduabs_next, bdvabs_next;
    logic        [obbsat_pkg::DMAG_W-1:0] dmag_reg;
    logic        [obbsat_pkg::EMAG_W-1:0] adu_reg, adv_reg, bdu_reg, bdv_reg;
    logic        [obbsat_pkg::HALF_W-1:0] ahw3_reg, ahh3_reg, bhw3_reg, bhh3_reg;

    // stage 4: extent terms
    logic [obbsat_pkg::DPROJ_W-1:0] dproj4_reg;
    logic [obbsat_pkg::EXT_W-1:0]   tau_reg, tav_reg, tbu_reg, tbv_reg;

    // stage 5: per-box extents
    logic [obbsat_pkg::DPROJ_W-1:0] dproj5_reg;
    logic [obbsat_pkg::RPAIR_W-1:0] ra_reg, rb_reg;

    // stage 6: compare
    logic [obbsat_pkg::RSUM_W-1:0] rsum_next;
    logic                          sep_reg;

    always_ff @(posedge clk)
    begin
        if (en.s2)
        begin
            pdx_reg  <= $signed(obbsat_pkg::PROD_W'(dx)) * $signed(obbsat_pkg::PROD_W'(lx));
            pdy_reg  <= $signed(obbsat_pkg::PROD_W'(dy)) * $signed(obbsat_pkg::PROD_W'(ly));
            au1_reg  <= $signed(obbsat_pkg::TERM_W'(lx)) *
                        $signed(obbsat_pkg::TERM_W'(a_axis_cos));
            au2_reg  <= $signed(obbsat_pkg::TERM_W'(ly)) *
                        $signed(obbsat_pkg::TERM_W'(a_axis_sin));
            av1_reg  <= $signed(obbsat_pkg::TERM_W'(ly)) *
                        $signed(obbsat_pkg::TERM_W'(a_axis_cos));
            av2_reg  <= $signed(obbsat_pkg::TERM_W'(lx)) *
                        $signed(obbsat_pkg::TERM_W'(a_axis_sin));
            bu1_reg  <= $signed(obbsat_pkg::TERM_W'(lx)) *
                        $signed(obbsat_pkg::TERM_W'(b_axis_cos));
            bu2_reg  <= $signed(obbsat_pkg::TERM_W'(ly)) *
                        $signed(obbsat_pkg::TERM_W'(b_axis_sin));
            bv1_reg  <= $signed(obbsat_pkg::TERM_W'(ly)) *
                        $signed(obbsat_pkg::TERM_W'(b_axis_cos));
            bv2_reg  <= $signed(obbsat_pkg::TERM_W'(lx)) *
                        $signed(obbsat_pkg::TERM_W'(b_axis_sin));
            ahw2_reg <= a_half_width;
            ahh2_reg <= a_half_height;
            bhw2_reg <= b_half_width;
            bhh2_reg <= b_half_height;
        end
    end

    // dot products and their magnitudes; up axis is (-sin, cos)
    always_comb
    begin
        dsum_next   = $signed(obbsat_pkg::DSUM_W'(pdx_reg)) + $signed(obbsat_pkg::DSUM_W'(pdy_reg));
        dabs_next   = dsum_next[obbsat_pkg::DSUM_W-1] ? -dsum_next : dsum_next;
        adu_next    = $signed(obbsat_pkg::TSUM_W'(au1_reg)) + $signed(obbsat_pkg::TSUM_W'(au2_reg));
        adv_next    = $signed(obbsat_pkg::TSUM_W'(av1_reg)) - $signed(obbsat_pkg::TSUM_W'(av2_reg));
        bdu_next    = $signed(obbsat_pkg::TSUM_W'(bu1_reg)) + $signed(obbsat_pkg::TSUM_W'(bu2_reg));
        bdv_next    = $signed(obbsat_pkg::TSUM_W'(bv1_reg)) - $signed(obbsat_pkg::TSUM_W'(bv2_reg));
        aduabs_next = adu_next[obbsat_pkg::TSUM_W-1] ? -adu_next : adu_next;
        advabs_next = adv_next[obbsat_pkg::TSUM_W-1] ? -adv_next : adv_next;
        bduabs_next = bdu_next[obbsat_pkg::TSUM_W-1] ? -bdu_next : bdu_next;
        bdvabs_next = bdv_next[obbsat_pkg::TSUM_W-1] ? -bdv_next : bdv_next;
    end

    always_ff @(posedge clk)
    begin
        if (en.s3)
        begin
            dmag_reg <= dabs_next[obbsat_pkg::DMAG_W-1:0];
            adu_reg  <= aduabs_next[obbsat_pkg::EMAG_W-1:0];
            adv_reg  <= advabs_next[obbsat_pkg::EMAG_W-1:0];
            bdu_reg  <= bduabs_next[obbsat_pkg::EMAG_W-1:0];
            bdv_reg  <= bdvabs_next[obbsat_pkg::EMAG_W-1:0];
            ahw3_reg <= ahw2_reg;
            ahh3_reg <= ahh2_reg;
            bhw3_reg <= bhw2_reg;
            bhh3_reg <= bhh2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en.s4)
        begin
            dproj4_reg <= {dmag_reg, {obbsat_pkg::FRAC_SH{1'b0}}};
            tau_reg    <= obbsat_pkg::EXT_W'(ahw3_reg) * obbsat_pkg::EXT_W'(adu_reg);
            tav_reg    <= obbsat_pkg::EXT_W'(ahh3_reg) * obbsat_pkg::EXT_W'(adv_reg);
            tbu_reg    <= obbsat_pkg::EXT_W'(bhw3_reg) * obbsat_pkg::EXT_W'(bdu_reg);
            tbv_reg    <= obbsat_pkg::EXT_W'(bhh3_reg) * obbsat_pkg::EXT_W'(bdv_reg);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en.s5)
        begin
            dproj5_reg <= dproj4_reg;
            ra_reg     <= obbsat_pkg::RPAIR_W'(tau_reg) + obbsat_pkg::RPAIR_W'(tav_reg);
            rb_reg     <= obbsat_pkg::RPAIR_W'(tbu_reg) + obbsat_pkg::RPAIR_W'(tbv_reg);
        end
    end

    assign rsum_next = obbsat_pkg::RSUM_W'(ra_reg) + obbsat_pkg::RSUM_W'(rb_reg);

    // strict compare: touching is not a separation
    always_ff @(posedge clk)
    begin
        if (en.s6)
        begin
            sep_reg <= obbsat_pkg::RSUM_W'(dproj5_reg) > rsum_next;
        end
    end

    assign sep = sep_reg;

endmodule

// File: rtl/obb_obb_separating_axis_test_unit.sv
`timescale 1ns / 1ps
// Overlap test for two oriented rectangles in the plane by the separating
// axis method. Each input beat carries both boxes (center in signed q16.16,
// half sizes in q15.16, right axis as cos/sin in q1.14); each output beat
// carries one bit, set when none of the four box axes strictly separates the
// boxes, so touching boxes count as overlapping. All projections are exact
// at q.44 and nothing saturates; axis components are used as given, so a
// non-unit axis scales that box's extents. The block is a seven-stage
// pipeline: it takes one beat every cycle while the output side keeps up,
// and each result leaves through the stage registers in order. Each stage
// holds its valid bit and loads only when the stage after it has room, so a
// stall on the output fills the bubbles first and then holds the input off;
// nothing is dropped or repeated. Stage one forms the center difference and
// the four candidate axes, the remaining stages run in four parallel lanes
// (products, magnitudes, extent products, per-box sums, final add and
// compare), and the last register combines the lanes.
// depends on obbsat_pkg, obbsat_axis_lane and the assertion macro header

`include "obb_obb_separating_axis_test_unit_defines.svh"

module obb_obb_separating_axis_test_unit (
    input  logic                                 clk,
    input  logic                                 rst_n,
    // input channel
    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  logic signed [obbsat_pkg::CTR_W-1:0]  a_center_x,
    input  logic signed [obbsat_pkg::CTR_W-1:0]  a_center_y,
    input  logic        [obbsat_pkg::HALF_W-1:0] a_half_width,
    input  logic        [obbsat_pkg::HALF_W-1:0] a_half_height,
    input  logic signed [obbsat_pkg::AX_W-1:0]   a_axis_cos,
    input  logic signed [obbsat_pkg::AX_W-1:0]   a_axis_sin,
    input  logic signed [obbsat_pkg::CTR_W-1:0]  b_center_x,
    input  logic signed [obbsat_pkg::CTR_W-1:0]  b_center_y,
    input  logic        [obbsat_pkg::HALF_W-1:0] b_half_width,
    input  logic        [obbsat_pkg::HALF_W-1:0] b_half_height,
    input  logic signed [obbsat_pkg::AX_W-1:0]   b_axis_cos,
    input  logic signed [obbsat_pkg::AX_W-1:0]   b_axis_sin,
    // output channel
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output logic                                 overlapping
);

    // per-stage valid bits, stage one at bit zero, output register at the top
    logic [obbsat_pkg::NUM_STAGES-1:0] v_reg;
    logic [obbsat_pkg::NUM_STAGES-1:0] v_next;
    // a stage loads when it is empty or the stage after it moves
    logic [obbsat_pkg::NUM_STAGES-1:0] en;
    obbsat_pkg::lane_en_t              lane_en;

    // stage one payload
    logic signed [obbsat_pkg::DIF_W-1:0]  dx_reg, dy_reg;
    logic signed [obbsat_pkg::LAX_W-1:0]  lx_reg [obbsat_pkg::NUM_AXES];
    logic signed [obbsat_pkg::LAX_W-1:0]  ly_reg [obbsat_pkg::NUM_AXES];
    logic        [obbsat_pkg::HALF_W-1:0] ahw_reg, ahh_reg, bhw_reg, bhh_reg;
    logic signed [obbsat_pkg::AX_W-1:0]   ac_reg, as_reg, bc_reg, bs_reg;

    // per-lane separation flags and the output register
    logic [obbsat_pkg::NUM_AXES-1:0] sep;
    logic                            overlapping_reg;

    // ready chain from the output back to the input
    assign en[obbsat_pkg::NUM_STAGES-1] = !v_reg[obbsat_pkg::NUM_STAGES-1] || out_ready;

    for (genvar k = 0; k < obbsat_pkg::NUM_STAGES - 1; k++)
    begin : g_en
        assign en[k] = !v_reg[k] || en[k+1];
    end

    assign in_ready = en[0];
    assign v_next   = {v_reg[obbsat_pkg::NUM_STAGES-2:0], in_valid};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            v_reg <= (en & v_next) | (~en & v_reg);
        end
    end

    assign lane_en = '{s2: en[1], s3: en[2], s4: en[3], s5: en[4], s6: en[5]};

    // stage one: center difference and the four candidate axes
    // a right, a up = (-sin, cos), b right, b up
    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            dx_reg    <= obbsat_pkg::DIF_W'(a_center_x) - obbsat_pkg::DIF_W'(b_center_x);
            dy_reg    <= obbsat_pkg::DIF_W'(a_center_y) - obbsat_pkg::DIF_W'(b_center_y);
            lx_reg[0] <= obbsat_pkg::LAX_W'(a_axis_cos);
            ly_reg[0] <= obbsat_pkg::LAX_W'(a_axis_sin);
            lx_reg[1] <= -obbsat_pkg::LAX_W'(a_axis_sin);
            ly_reg[1] <= obbsat_pkg::LAX_W'(a_axis_cos);
            lx_reg[2] <= obbsat_pkg::LAX_W'(b_axis_cos);
            ly_reg[2] <= obbsat_pkg::LAX_W'(b_axis_sin);
            lx_reg[3] <= -obbsat_pkg::LAX_W'(b_axis_sin);
            ly_reg[3] <= obbsat_pkg::LAX_W'(b_axis_cos);
            ahw_reg   <= a_half_width;
            ahh_reg   <= a_half_height;
            bhw_reg   <= b_half_width;
            bhh_reg   <= b_half_height;
            ac_reg    <= a_axis_cos;
            as_reg    <= a_axis_sin;
            bc_reg    <= b_axis_cos;
            bs_reg    <= b_axis_sin;
        end
    end

    // stages two to six: one lane per candidate axis
    for (genvar i = 0; i < obbsat_pkg::NUM_AXES; i++)
    begin : g_lane
        obbsat_axis_lane u_lane (
            .clk           (clk),
            .en            (lane_en),
            .dx            (dx_reg),
            .dy            (dy_reg),
            .lx            (lx_reg[i]),
            .ly            (ly_reg[i]),
            .a_half_width  (ahw_reg),
            .a_half_height (ahh_reg),
            .a_axis_cos    (ac_reg),
            .a_axis_sin    (as_reg),
            .b_half_width  (bhw_reg),
            .b_half_height (bhh_reg),
            .b_axis_cos    (bc_reg),
            .b_axis_sin    (bs_reg),
            .sep           (sep[i])
        );
    end

    // stage seven: overlap unless some axis separates
    always_ff @(posedge clk)
    begin
        if (en[obbsat_pkg::NUM_STAGES-1])
        begin
            overlapping_reg <= ~|sep;
        end
    end

    assign out_valid   = v_reg[obbsat_pkg::NUM_STAGES-1];
    assign overlapping = overlapping_reg;

    // a drained output stage means the whole chain has room
    `OBBSAT_ASSERT_IMPL(a_ready_when_drained, !out_valid, in_ready, "input held off with empty output")
    // a full pipeline under output stall must hold the input off
    `OBBSAT_ASSERT_IMPL(a_full_stall, (&v_reg) && !out_ready, !in_ready, "input taken into full pipe")
    // a taken beat lands in stage one
    `OBBSAT_ASSERT_NEXT(a_accept_lands, in_valid && in_ready, v_reg[0], "accepted beat lost at entry")
    // a stalled stage keeps its beat
    `OBBSAT_ASSERT_NEXT(a_stall_holds, |(v_reg & ~en), (($past(v_reg) & ~$past(en) & ~v_reg) == '0), "stalled beat dropped")

endmodule
